### hw/rtl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CFE_ASSERT_IMP(lbl, clk_sig, rst_sig, pre, post) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |-> (post)) \
        else $error("cfe assertion failed");

// next-cycle implication, checked out of reset
`define CFE_ASSERT_NXT(lbl, clk_sig, rst_sig, pre, post) \
    lbl: assert property (@(posedge clk_sig) disable iff (!rst_sig) (pre) |=> (post)) \
        else $error("cfe assertion failed");

`endif

### hw/rtl/cfe_pkg.sv
package cfe_pkg;

    localparam int NUM_LEDS_DEF = 128;

    localparam int LED_W     = 7;
    localparam int CH_W      = 16;
    localparam int BYTE_W    = 8;
    localparam int STEP_W    = 11;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    localparam logic [STEP_W-1:0] FADE_IN_RST  = 11'd512;
    localparam logic [STEP_W-1:0] FADE_OUT_RST = 11'd1024;

    localparam logic [CFG_IDX_W-1:0] REG_FADE_IN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FADE_OUT = 2'd1;

    localparam logic CMD_SET  = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef logic [CH_W-1:0] chan_t;
    typedef chan_t [2:0] color_t;

    typedef struct packed {
        color_t tgt;
        color_t cur;
        color_t src;
    } entry_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // floor(x / 257): with x = 256*hi + lo the answer is hi when lo >= hi, else hi - 1
    function automatic logic [BYTE_W-1:0] to_byte(input chan_t x);
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        hi = x[CH_W-1:BYTE_W];
        lo = x[BYTE_W-1:0];
        return (lo >= hi) ? hi : hi - 8'd1;
    endfunction

endpackage

### hw/rtl/cfe_div.sv
module cfe_div
    import cfe_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  chan_t             dividend,
    input  logic [STEP_W-1:0] divisor,
    output chan_t             quotient,
    output div_stat_t         stat
);

`include "assert_macros.svh"

    // two restoring steps per cycle
    localparam int DIV_ITER = CH_W / 2;
    localparam int CNT_W    = (DIV_ITER > 1) ? $clog2(DIV_ITER) : 1;
    localparam int REM_W    = STEP_W + 1;

    chan_t              dvd_reg, dvd_next;
    chan_t              quo_reg, quo_next;
    logic [STEP_W-1:0]  dsr_reg, dsr_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [REM_W:0]     step1;
    logic [REM_W:0]     step2;

    function automatic logic [REM_W:0] rs_step(input logic [REM_W-1:0] r,
                                               input logic b,
                                               input logic [STEP_W-1:0] d);
        logic [REM_W:0] t;
        logic [REM_W:0] dx;
        t  = {r, b};
        dx = (REM_W + 1)'(d);
        if (t >= dx)
        begin
            t = t - dx;
            return {t[REM_W-1:0], 1'b1};
        end
        return {t[REM_W-1:0], 1'b0};
    endfunction

    always_comb
    begin
        step1 = rs_step(rem_reg, dvd_reg[CH_W-1], dsr_reg);
        step2 = rs_step(step1[REM_W:1], dvd_reg[CH_W-2], dsr_reg);

        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start)
        begin
            dvd_next  = dividend;
            dsr_next  = divisor;
            quo_next  = '0;
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[CH_W-3:0], 2'b00};
            quo_next = {quo_reg[CH_W-3:0], step1[0], step2[0]};
            rem_next = step2[REM_W:1];
            if (cnt_reg == CNT_W'(DIV_ITER - 1))
            begin
                cnt_next  = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    `CFE_ASSERT_NXT(a_start_busy, clk, rst_n, start, busy_reg)
    `CFE_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg)
    `CFE_ASSERT_IMP(a_cnt_idle, clk, rst_n, cnt_reg != '0, busy_reg)

endmodule

### hw/rtl/cfe_store.sv
module cfe_store
    import cfe_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF,
    parameter int AW       = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t                mem [NUM_LEDS];
    entry_t                rd_data_reg;
    logic [NUM_LEDS-1:0]   valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // an entry never written reads as black
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

### hw/rtl/led_linear_crossfade_engine.sv
// set command: load, write, output, then idle takes the next word
// step command: load, per channel a check and a division if it moves, write, output
// each moving channel runs one division through the shared 2-bit-per-cycle divider
// rst_n clears the fade registers to 512/1024 and marks every led black at once
// (per-entry valid bits, no clearing pass), output word dropped
module led_linear_crossfade_engine
    import cfe_pkg::*;
#(
    parameter int NUM_LEDS = NUM_LEDS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // led_index[6:0], target_red[22:7], target_green[38:23], target_blue[54:39], zero[55]
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // cmd[0]
    input  logic                 s_axis_tuser,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // out_led[6:0], out_red[14:7], out_green[22:15], out_blue[30:23], zero[31]
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    // settled[0]
    output logic                 m_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STEP_W-1:0]    cfg_data
);

`include "assert_macros.svh"

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int XW = (AW > LED_W) ? AW : LED_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_CHAN,
        S_DIV,
        S_WRITE,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic                cmd_reg, cmd_next;
    logic [LED_W-1:0]    led_reg, led_next;
    color_t              req_reg, req_next;
    logic                in_range_reg, in_range_next;
    entry_t              ent_reg, ent_next;
    logic [1:0]          ch_reg, ch_next;
    logic [STEP_W-1:0]   fade_in_reg, fade_in_next;
    logic [STEP_W-1:0]   fade_out_reg, fade_out_next;
    logic                m_valid_reg, m_valid_next;
    logic [LED_W-1:0]    out_led_reg, out_led_next;
    logic [BYTE_W-1:0]   out_r_reg, out_r_next;
    logic [BYTE_W-1:0]   out_g_reg, out_g_next;
    logic [BYTE_W-1:0]   out_b_reg, out_b_next;
    logic                settled_reg, settled_next;

    logic [LED_W-1:0]    in_led;
    logic [XW-1:0]       in_led_x;
    logic [XW-1:0]       led_reg_x;
    logic                in_range;
    logic                mem_rd;
    logic                mem_wr;
    entry_t              mem_rd_data;
    entry_t              wr_ent;

    chan_t               cur_c;
    chan_t               tgt_c;
    chan_t               src_c;
    logic                rising;
    chan_t               span;
    chan_t               gap;
    chan_t               mag_min;
    chan_t               mag;
    chan_t               moved;
    logic [STEP_W-1:0]   steps_raw;
    logic [STEP_W-1:0]   steps;
    logic                last_ch;
    logic                at_target;

    logic                div_start;
    chan_t               div_q;
    div_stat_t           div_stat;

    assign in_led    = s_axis_tdata[LED_W-1:0];
    assign in_led_x  = XW'(in_led);
    assign led_reg_x = XW'(led_reg);
    assign in_range  = (XW + 1)'(in_led) < (XW + 1)'(NUM_LEDS);

    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    // per-channel step arithmetic on the channel being worked
    always_comb
    begin
        cur_c     = ent_reg.cur[ch_reg];
        tgt_c     = ent_reg.tgt[ch_reg];
        src_c     = ent_reg.src[ch_reg];
        rising    = tgt_c > cur_c;
        span      = (tgt_c >= src_c) ? tgt_c - src_c : src_c - tgt_c;
        gap       = rising ? tgt_c - cur_c : cur_c - tgt_c;
        steps_raw = rising ? fade_in_reg : fade_out_reg;
        steps     = (steps_raw == '0) ? STEP_W'(1) : steps_raw;
        mag_min   = (div_q == '0) ? CH_W'(1) : div_q;
        mag       = (mag_min > gap) ? gap : mag_min;
        moved     = rising ? cur_c + mag : cur_c - mag;
        last_ch   = (ch_reg == 2'd2);
        at_target = (ent_reg.cur == ent_reg.tgt);
    end

    // on a step command, once every channel has arrived the source follows the target
    always_comb
    begin
        wr_ent = ent_reg;
        if (cmd_reg == CMD_STEP && at_target)
        begin
            wr_ent.src = ent_reg.tgt;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        led_next      = led_reg;
        req_next      = req_reg;
        in_range_next = in_range_reg;
        ent_next      = ent_reg;
        ch_next       = ch_reg;
        fade_in_next  = fade_in_reg;
        fade_out_next = fade_out_reg;
        m_valid_next  = m_valid_reg;
        out_led_next  = out_led_reg;
        out_r_next    = out_r_reg;
        out_g_next    = out_g_reg;
        out_b_next    = out_b_reg;
        settled_next  = settled_reg;
        mem_rd        = 1'b0;
        mem_wr        = 1'b0;
        div_start     = 1'b0;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_FADE_IN:  fade_in_next  = cfg_data;
                REG_FADE_OUT: fade_out_next = cfg_data;
                default:      ;
            endcase
        end

        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    mem_rd        = in_range;
                    cmd_next      = s_axis_tuser;
                    led_next      = in_led;
                    req_next[0]   = s_axis_tdata[LED_W +: CH_W];
                    req_next[1]   = s_axis_tdata[LED_W + CH_W +: CH_W];
                    req_next[2]   = s_axis_tdata[LED_W + 2 * CH_W +: CH_W];
                    in_range_next = in_range;
                    state_next    = S_LOAD;
                end
            end
            S_LOAD:
            begin
                ent_next = mem_rd_data;
                ch_next  = 2'd0;
                if (!in_range_reg)
                begin
                    state_next = S_OUT;
                end
                else if (cmd_reg == CMD_SET)
                begin
                    if (mem_rd_data.tgt != req_reg)
                    begin
                        ent_next.tgt = req_reg;
                        ent_next.src = mem_rd_data.cur;
                    end
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_CHAN;
                end
            end
            S_CHAN:
            begin
                if (cur_c == tgt_c)
                begin
                    if (last_ch)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        ch_next = ch_reg + 2'd1;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    ent_next.cur[ch_reg] = moved;
                    if (last_ch)
                    begin
                        state_next = S_WRITE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_CHAN;
                    end
                end
            end
            S_WRITE:
            begin
                mem_wr     = 1'b1;
                ent_next   = wr_ent;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    out_led_next = led_reg;
                    if (in_range_reg)
                    begin
                        out_r_next   = to_byte(ent_reg.cur[0]);
                        out_g_next   = to_byte(ent_reg.cur[1]);
                        out_b_next   = to_byte(ent_reg.cur[2]);
                        settled_next = at_target;
                    end
                    else
                    begin
                        out_r_next   = '0;
                        out_g_next   = '0;
                        out_b_next   = '0;
                        settled_next = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ch_reg       <= 2'd0;
            fade_in_reg  <= FADE_IN_RST;
            fade_out_reg <= FADE_OUT_RST;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ch_reg       <= ch_next;
            fade_in_reg  <= fade_in_next;
            fade_out_reg <= fade_out_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        led_reg      <= led_next;
        req_reg      <= req_next;
        in_range_reg <= in_range_next;
        ent_reg      <= ent_next;
        out_led_reg  <= out_led_next;
        out_r_reg    <= out_r_next;
        out_g_reg    <= out_g_next;
        out_b_reg    <= out_b_next;
        settled_reg  <= settled_next;
    end

    cfe_store #(
        .NUM_LEDS (NUM_LEDS),
        .AW       (AW)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd),
        .rd_addr (in_led_x[AW-1:0]),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr),
        .wr_addr (led_reg_x[AW-1:0]),
        .wr_data (wr_ent)
    );

    cfe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (span),
        .divisor  (steps),
        .quotient (div_q),
        .stat     (div_stat)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = settled_reg;
    assign m_axis_tdata  = {1'b0, out_b_reg, out_g_reg, out_r_reg, out_led_reg};

    `CFE_ASSERT_IMP(a_wr_in_range, clk, rst_n, mem_wr, in_range_reg)
    `CFE_ASSERT_NXT(a_busy_after_take, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `CFE_ASSERT_IMP(a_word_from_out, clk, rst_n, $rose(m_valid_reg), $past(state_reg == S_OUT))

endmodule
